FILE: rtl/mip_chain_subresource_locator_assert.svh
// Assertion macros for the mip chain subresource locator.
`ifndef MIP_CHAIN_SUBRESOURCE_LOCATOR_ASSERT_SVH
`define MIP_CHAIN_SUBRESOURCE_LOCATOR_ASSERT_SVH

// Checked on every clock edge outside reset.
`define MCSL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MCSL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mcsl_pkg.sv
// Types, codes and helper functions shared by the mip chain locator.
package mcsl_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_TEXEL_BYTES     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_OR_LAYERS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIP_COUNT       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_KIND    = 3'd5;

	localparam logic [1:0] KIND_PLAIN  = 2'd0;
	localparam logic [1:0] KIND_ARRAY  = 2'd1;
	localparam logic [1:0] KIND_VOLUME = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_MIP   = 2'd1;
	localparam logic [1:0] STATUS_BAD_SLICE = 2'd2;

	typedef struct packed {
		logic [3:0]  mip_level;
		logic [10:0] array_slice;
	} req_t;

	typedef struct packed {
		logic [47:0] byte_offset;
		logic [47:0] byte_size;
		logic [47:0] total_bytes;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_SLICE,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic       start;
		logic       issue;
		logic [3:0] level;
		logic       slice_mul;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic       busy;
		logic [3:0] mip_cnt;
	} sts_t;

	// max(base >> m, 1); a zero base also reads as one
	function automatic logic [14:0] dim15(logic [14:0] base, logic [3:0] m);
		logic [14:0] v;
		v = base >> m;
		return (v == 15'd0) ? 15'd1 : v;
	endfunction

	function automatic logic [11:0] dim12(logic [11:0] base, logic [3:0] m);
		logic [11:0] v;
		v = base >> m;
		return (v == 12'd0) ? 12'd1 : v;
	endfunction

endpackage

FILE: rtl/mcsl_datapath.sv
// Config registers, level size pipeline, accumulators and result register.
module mcsl_datapath import mcsl_pkg::*; #(
	parameter int MAX_MIPS = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  req_t                  req,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output rsp_t                  rsp
);

	localparam logic [4:0] MaxMips = 5'(MAX_MIPS);

	logic [4:0]  tb_q;
	logic [14:0] bw_q;
	logic [14:0] bh_q;
	logic [11:0] dol_q;
	logic [3:0]  mc_q;
	logic [1:0]  kind_q;

	logic [3:0]  mip_q;
	logic [10:0] slice_q;

	logic        vld_s1, vld_s2, vld_s3;
	logic [3:0]  lvl_s1, lvl_s2, lvl_s3;
	logic [19:0] p1_s1;
	logic [14:0] h_s1;
	logic [11:0] d_s1, d_s2;
	logic [34:0] plane_s2;
	logic [46:0] lb_s3;

	logic [34:0] plane_q;
	logic [11:0] pdep_q;
	logic [45:0] sp_q;
	logic [46:0] sz_q;
	logic [47:0] total_q;
	logic [47:0] off_q;

	logic [3:0]  eff_cnt;
	logic [11:0] lvl_depth;
	logic        is_vol;
	logic        is_arr;
	logic [1:0]  status_c;

	assign eff_cnt = ({1'b0, mc_q} < MaxMips) ? mc_q : MaxMips[3:0];
	assign is_vol  = (kind_q == KIND_VOLUME);
	assign is_arr  = (kind_q == KIND_ARRAY) || is_vol;
	assign lvl_depth = is_vol ? dim12(dol_q, cmd.level) : dol_q;

	assign sts.busy    = vld_s1 | vld_s2 | vld_s3;
	assign sts.mip_cnt = eff_cnt;

	always_comb begin
		if (mip_q >= eff_cnt) begin
			status_c = STATUS_BAD_MIP;
		end else if ({1'b0, slice_q} >= dol_q) begin
			status_c = STATUS_BAD_SLICE;
		end else begin
			status_c = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tb_q   <= 5'd4;
			bw_q   <= 15'd1;
			bh_q   <= 15'd1;
			dol_q  <= 12'd1;
			mc_q   <= 4'd1;
			kind_q <= KIND_PLAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEXEL_BYTES:     tb_q   <= cfg_data[4:0];
				CFG_BASE_WIDTH:      bw_q   <= cfg_data;
				CFG_BASE_HEIGHT:     bh_q   <= cfg_data;
				CFG_DEPTH_OR_LAYERS: dol_q  <= cfg_data[11:0];
				CFG_MIP_COUNT:       mc_q   <= cfg_data[3:0];
				CFG_TEXTURE_KIND:    kind_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// level size: texel * width, then * height, then * depth
	always_ff @(posedge clk) begin
		lvl_s1   <= cmd.level;
		p1_s1    <= 20'(tb_q) * 20'(dim15(bw_q, cmd.level));
		h_s1     <= dim15(bh_q, cmd.level);
		d_s1     <= lvl_depth;
		lvl_s2   <= lvl_s1;
		plane_s2 <= 35'(p1_s1) * 35'(h_s1);
		d_s2     <= d_s1;
		lvl_s3   <= lvl_s2;
		lb_s3    <= 47'(plane_s2) * 47'(d_s2);
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mip_q   <= req.mip_level;
			slice_q <= req.array_slice;
			total_q <= 48'd0;
			off_q   <= 48'd0;
		end else if (vld_s3) begin
			total_q <= total_q + 48'(lb_s3);
			if (lvl_s3 < mip_q) begin
				off_q <= off_q + 48'(lb_s3);
			end
		end
		if (vld_s2 && lvl_s2 == mip_q) begin
			plane_q <= plane_s2;
			pdep_q  <= d_s2;
		end
		if (cmd.slice_mul) begin
			sp_q <= 46'(plane_q) * 46'(slice_q);
			sz_q <= 47'(plane_q) * 47'(is_vol ? pdep_q : 12'd1);
		end
		if (cmd.load_out) begin
			rsp.status      <= status_c;
			rsp.total_bytes <= total_q;
			if (status_c == STATUS_OK) begin
				rsp.byte_offset <= off_q + (is_arr ? 48'(sp_q) : 48'd0);
				rsp.byte_size   <= 48'(sz_q);
			end else begin
				rsp.byte_offset <= 48'd0;
				rsp.byte_size   <= 48'd0;
			end
		end
	end

endmodule

FILE: rtl/mcsl_ctrl.sv
// Sequencer: walks the mip levels through the datapath and hands off the word.
module mcsl_ctrl import mcsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	logic [3:0] ctr_q, ctr_d;
	logic       out_vld_q;

	assign rsp_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ctr_q     <= 4'd0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ctr_q   <= ctr_d;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		ctr_d         = ctr_q;
		req_stall     = 1'b1;
		cmd.start     = 1'b0;
		cmd.issue     = 1'b0;
		cmd.level     = ctr_q;
		cmd.slice_mul = 1'b0;
		cmd.load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.start = 1'b1;
					ctr_d     = 4'd0;
					state_d   = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (ctr_q != sts.mip_cnt) begin
					cmd.issue = 1'b1;
					ctr_d     = ctr_q + 4'd1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = ST_SLICE;
				end
			end
			ST_SLICE: begin
				cmd.slice_mul = 1'b1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				// wait while the previous word is still held downstream
				if (!(out_vld_q && rsp_stall)) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/mip_chain_subresource_locator.sv
// Top level of the mip chain subresource locator.
//
//   channel  signals                         direction  accepted when
//   req      req_valid req_stall req         in         req_valid & !req_stall
//   rsp      rsp_valid rsp_stall rsp         out        rsp_valid & !rsp_stall
//   cfg      cfg_we cfg_index cfg_data       in         cfg_we
//
// One request walks min(mip_count, MAX_MIPS) levels from accept to result: one level enters
// the three stage multiply pipeline per cycle, then drain, slice multiply and result load.
// req_stall is high from accept until the result is loaded.
// Reset clears the config registers to their defaults and the sequencer to idle; no
// clearing pass. A stalled result word holds; a new request may be taken while it waits.
module mip_chain_subresource_locator import mcsl_pkg::*; #(
	parameter int MAX_MIPS = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "mip_chain_subresource_locator_assert.svh"

	cmd_t cmd;
	sts_t sts;

	mcsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mcsl_datapath #(
		.MAX_MIPS (MAX_MIPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

	`MCSL_ASSERT(a_hold_after_accept, req_valid && !req_stall |=> req_stall, "request taken while busy")
	`MCSL_ASSERT(a_err_zero, rsp_valid && rsp.status != STATUS_OK |-> rsp.byte_offset == 48'd0 && rsp.byte_size == 48'd0, "error word carries nonzero offset or size")
	`MCSL_ASSERT(a_load_idle, cmd.load_out |=> !req_stall, "sequencer not idle after result load")
	`MCSL_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !rsp_valid, "result valid during reset")

endmodule
